### rtl/core/cyclist_headwind_speed_solver_defines.svh
// assertion macros for the headwind speed solver
`ifndef CYCLIST_HEADWIND_SPEED_SOLVER_DEFINES_SVH
`define CYCLIST_HEADWIND_SPEED_SOLVER_DEFINES_SVH

// checked property, quiet while reset is high
`define CHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property, also across reset
`define CHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/chs_pkg.sv
// shared constants and types of the headwind speed solver
`default_nettype none
package chs_pkg;
  localparam int ITERATIONS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int POWER_FRAC = 8;
  localparam int BAL_SHIFT  = 3 * FRAC_BITS - POWER_FRAC;
  localparam int DRAG_NUM   = 49;
  localparam int DRAG_DEN   = 200;
  localparam logic [18:0] POWER_RESET = 19'd16384;

  typedef struct packed {
    logic               err;
    logic [21:0]        s;
    logic signed [22:0] h;
    logic [43:0]        ss;
    logic [27:0]        s49;
    logic [22:0]        lo;
    logic [22:0]        hi;
  } ctx_t;
endpackage
`default_nettype wire

### rtl/core/cyclist_headwind_speed_solver.sv
// headwind ground speed solver: entry stage, bisection chain, result register
//
//   channel   valid         stall         beat
//   item      item_valid    item_stall    still_speed, headwind
//   result    result_valid  result_stall  ground_speed, input_error
//   config    cfg_wr_en     -             cfg_wr_data
//
// one item per cycle while the result is not stalled; a result is offered after
// its item passes the entry register, six stages per bisection step and the result register
// the whole chain advances together; a stalled result holds every stage
// synchronous reset clears all valid bits and loads the default rider power
`default_nettype none
`include "cyclist_headwind_speed_solver_defines.svh"
module cyclist_headwind_speed_solver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [18:0] cfg_wr_data,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [21:0] still_speed,
  input  wire logic signed [22:0] headwind,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [22:0]      ground_speed,
  output logic             input_error
);
  logic en;
  logic [26:0] p200;
  logic [22:0] h_mag;
  logic [23:0] out_sum;
  logic chain_valid [chs_pkg::ITERATIONS+1];
  chs_pkg::ctx_t chain_ctx [chs_pkg::ITERATIONS+1];
  logic last_valid;
  chs_pkg::ctx_t last_ctx;

  assign en = !(result_valid && result_stall);
  assign item_stall = !en;
  assign h_mag = headwind[22] ? 23'(-headwind) : 23'(headwind);

  chs_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .p200        (p200)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else if (en) begin
      chain_valid[0] <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain_ctx[0].err <= (still_speed == 22'd0);
      chain_ctx[0].s   <= still_speed;
      chain_ctx[0].h   <= headwind;
      chain_ctx[0].ss  <= still_speed * still_speed;
      chain_ctx[0].s49 <= 28'(still_speed) * 28'(chs_pkg::DRAG_NUM);
      chain_ctx[0].lo  <= '0;
      chain_ctx[0].hi  <= {1'b0, still_speed} + h_mag;
    end
  end

  for (genvar i = 0; i < chs_pkg::ITERATIONS; i++) begin : g_step
    chs_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .p200      (p200),
      .in_valid  (chain_valid[i]),
      .in_ctx    (chain_ctx[i]),
      .out_valid (chain_valid[i+1]),
      .out_ctx   (chain_ctx[i+1])
    );
  end

  assign last_valid = chain_valid[chs_pkg::ITERATIONS];
  assign last_ctx   = chain_ctx[chs_pkg::ITERATIONS];
  assign out_sum    = {1'b0, last_ctx.lo} + {1'b0, last_ctx.hi};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      input_error  <= last_ctx.err;
      ground_speed <= last_ctx.err ? '0 : out_sum[23:1];
    end
  end

  `CHS_ASSERT(a_err_zero, result_valid && input_error |-> ground_speed == '0, "speed on error")
  `CHS_ASSERT(a_hold_input, result_valid && result_stall |-> item_stall, "input in stall")
  `CHS_ASSERT(a_bracket, last_valid |-> last_ctx.lo <= last_ctx.hi, "bracket inverted")
  `CHS_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid after reset")
endmodule
`default_nettype wire

### rtl/core/chs_cfg.sv
// rider power register, kept pre-scaled by the drag denominator
`default_nettype none
module chs_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [18:0] cfg_wr_data,
  output logic [26:0]      p200
);
  always_ff @(posedge clk) begin
    if (rst) begin
      p200 <= 27'({8'b0, chs_pkg::POWER_RESET} * 27'(chs_pkg::DRAG_DEN));
    end else if (cfg_wr_en) begin
      p200 <= 27'({8'b0, cfg_wr_data} * 27'(chs_pkg::DRAG_DEN));
    end
  end
endmodule
`default_nettype wire

### rtl/core/chs_step.sv
// one bisection step: six register stages deciding the sign of the balance
`default_nettype none
module chs_step (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic [26:0]  p200,
  input  wire logic         in_valid,
  input  wire chs_pkg::ctx_t in_ctx,
  output logic              out_valid,
  output chs_pkg::ctx_t     out_ctx
);
  logic v1, v2, v3, v4, v5;
  chs_pkg::ctx_t c1, c2, c3, c4, c5;
  chs_pkg::ctx_t ctx_next;
  logic [22:0] m1, m2, m3, m4, m5;

  logic [23:0] lh_sum;
  logic signed [24:0] a1;
  logic signed [23:0] dv1;
  logic signed [49:0] asq2;
  logic [50:0] sv2, sv3;
  logic signed [51:0] pdv2, pdv3, pdv4, pdv5;
  logic [23:0] a_mag;
  logic signed [49:0] d3;
  logic [63:0] pp0;
  logic [50:0] pp1;
  logic signed [50:0] pp2;
  logic signed [37:0] pp3;
  logic signed [101:0] tb5;
  logic signed [101:0] t0, t1, t2, t3, ta, total;
  logic neg;

  assign lh_sum = {1'b0, in_ctx.lo} + {1'b0, in_ctx.hi};
  assign a_mag  = 24'(a1[24] ? -a1 : a1);

  assign t0 = $signed({38'b0, pp0});
  assign t1 = $signed({19'b0, pp1, 32'b0});
  assign t2 = $signed({{19{pp2[50]}}, pp2, 32'b0});
  assign t3 = $signed({pp3, 64'b0});
  assign ta = 102'(pdv5) <<< chs_pkg::BAL_SHIFT;
  assign total = ta + tb5;
  assign neg = total[101];

  // negative balance means the root lies above the midpoint
  always_comb begin
    ctx_next = c5;
    if (neg) begin
      ctx_next.lo = m5;
    end else begin
      ctx_next.hi = m5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // midpoint, speed into the wind and offset from still speed
      c1  <= in_ctx;
      m1  <= lh_sum[23:1];
      a1  <= $signed({2'b0, lh_sum[23:1]}) + $signed({{2{in_ctx.h[22]}}, in_ctx.h});
      dv1 <= $signed({1'b0, lh_sum[23:1]}) - $signed({2'b0, in_ctx.s});
      // signed square of relative air speed and the two scale products
      c2   <= c1;
      m2   <= m1;
      asq2 <= a1 * $signed({1'b0, a_mag});
      sv2  <= 51'(c1.s49 * m1);
      pdv2 <= 52'($signed({1'b0, p200}) * dv1);
      c3   <= c2;
      m3   <= m2;
      d3   <= asq2 - $signed({6'b0, c2.ss});
      sv3  <= sv2;
      pdv3 <= pdv2;
      // wide product split into four partial products
      c4   <= c3;
      m4   <= m3;
      pp0  <= sv3[31:0] * d3[31:0];
      pp1  <= 51'(sv3[50:32] * d3[31:0]);
      pp2  <= 51'($signed({1'b0, sv3[31:0]}) * $signed(d3[49:32]));
      pp3  <= 38'($signed({1'b0, sv3[50:32]}) * $signed(d3[49:32]));
      pdv4 <= pdv3;
      c5   <= c4;
      m5   <= m4;
      tb5  <= t0 + t1 + t2 + t3;
      pdv5 <= pdv4;
      out_ctx <= ctx_next;
    end
  end
endmodule
`default_nettype wire

### tb/cyclist_headwind_speed_solver_test.sv
// testbench for the headwind ground speed solver: directed and random beats
`timescale 1ns / 100ps
`default_nettype none
module cyclist_headwind_speed_solver_test;

  typedef struct {
    logic [22:0] speed;
    logic        err;
  } speed_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [18:0] cfg_wr_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [21:0] still_speed = '0;
  logic signed [22:0] headwind = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [22:0] ground_speed;
  logic        input_error;

  logic [18:0]   power_setting = chs_pkg::POWER_RESET;
  speed_result_t pending_speeds[$];
  int            fail_count = 0;
  int            idle_cycles = 0;

  localparam int PIPE_CYCLES = 2 + 6 * chs_pkg::ITERATIONS;
  localparam int WATCHDOG_LIMIT = 40 * PIPE_CYCLES;

  always #6 clk = ~clk;

  cyclist_headwind_speed_solver dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .item_valid(item_valid), .item_stall(item_stall), .still_speed(still_speed),
    .headwind(headwind), .result_valid(result_valid), .result_stall(result_stall),
    .ground_speed(ground_speed), .input_error(input_error)
  );

  // exact sign of the power balance at speed v
  function automatic bit drag_exceeds_power(longint v, longint s, longint h,
                                            logic [18:0] p);
    logic signed [129:0] lhs;
    logic signed [129:0] rhs;
    longint a;
    longint aa;
    a = v + h;
    aa = (a < 0) ? -a : a;
    lhs = 130'(chs_pkg::DRAG_DEN * longint'(p) * (v - s)) <<< chs_pkg::BAL_SHIFT;
    rhs = 130'(chs_pkg::DRAG_NUM * s * v) * 130'(a * aa - s * s);
    return (lhs + rhs) < 0;
  endfunction

  function automatic speed_result_t solve_ground_speed(logic [21:0] still,
                                                       logic signed [22:0] wind);
    speed_result_t r;
    longint s;
    longint h;
    longint lo;
    longint hi;
    longint mid;
    s = longint'(still);
    h = longint'(wind);
    r.err = (s == 0);
    r.speed = '0;
    if (s != 0) begin
      lo = 0;
      hi = s + ((h < 0) ? -h : h);
      for (int i = 0; i < chs_pkg::ITERATIONS; i++) begin
        mid = (lo + hi) >>> 1;
        if (drag_exceeds_power(mid, s, h, power_setting)) lo = mid;
        else hi = mid;
      end
      r.speed = 23'((lo + hi) >>> 1);
    end
    return r;
  endfunction

  // valid stays high after the beat is taken until the next gap or drain
  task automatic send_edge(logic [21:0] still, logic signed [22:0] wind);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    still_speed <= still;
    headwind <= wind;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_speeds.push_back(solve_ground_speed(still, wind));
  endtask

  task automatic drain_pipe();
    item_valid <= 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES + 4) @(posedge clk);
  endtask

  task automatic set_power(logic [18:0] p);
    drain_pipe();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    power_setting = p;
  endtask

  function automatic logic signed [22:0] random_wind();
    if ($urandom_range(0, 9) == 0) return 23'($urandom);
    return 23'($signed($urandom_range(0, 5242880)) - 2621440);
  endfunction

  task automatic test_directed_extremes();
    send_edge(22'd0, 23'sd0);
    send_edge(22'd0, -23'sd2621440);
    send_edge(22'h3FFFFF, 23'sd2621440);
    send_edge(22'h3FFFFF, -23'sd2621440);
    send_edge(22'd1, 23'sd0);
    send_edge(22'd1, 23'sd1);
    send_edge(22'd655360, 23'sd0);
    send_edge(22'd655360, 23'sd327680);
    send_edge(22'd655360, -23'sd327680);
    send_edge(22'd327680, 23'h3FFFFF);
    send_edge(22'd327680, 23'h400000);
    send_edge(22'h2AAAAA, 23'h555555);
    send_edge(22'h155555, 23'h2AAAAA);
  endtask

  task automatic test_power_settings();
    logic [18:0] settings[4];
    settings = '{19'd0, 19'h7FFFF, 19'd1, 19'd65536};
    foreach (settings[k]) begin
      set_power(settings[k]);
      send_edge(22'd0, 23'sd0);
      send_edge(22'd655360, 23'sd131072);
      send_edge(22'h3FFFFF, -23'sd2621440);
      send_edge(22'd1, 23'h400000);
    end
  endtask

  task automatic test_random_edges();
    for (int phase = 0; phase < 5; phase++) begin
      set_power(19'($urandom));
      for (int n = 0; n < 200; n++)
        send_edge((n % 50 == 0) ? 22'd0 : 22'($urandom), random_wind());
    end
  endtask

  // result side stall pattern
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      if (hold != 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    speed_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_speeds.size() == 0) begin
        $error("unexpected result beat ground_speed=%0d", ground_speed);
        fail_count++;
      end else begin
        want = pending_speeds.pop_front();
        if (ground_speed !== want.speed) begin
          $error("ground_speed expected %0d actual %0d", want.speed, ground_speed);
          fail_count++;
        end
        if (input_error !== want.err) begin
          $error("input_error expected %0d actual %0d", want.err, input_error);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_power_settings();
    test_random_edges();
    drain_pipe();
    if (fail_count == 0 && pending_speeds.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
